[rtl/dhsd_pkg.sv]
// Shared constants, types and hash arithmetic for the double-hash string dictionary.
`timescale 1ns / 1ps
package dhsd_pkg;

    // Table geometry and string limits
    localparam int TABLE_SIZE  = 4093;
    localparam int MAX_SYMBOLS = 11;

    // Field widths
    localparam int SYMS_W  = 22;
    localparam int LEN_W   = 4;
    localparam int KEY_W   = 26;
    localparam int DIGIT_W = 3;

    // Derived widths
    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam int IDX_W  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int SHF_W  = IDX_W + 1;
    // rem * 5 + digit stays below 5 * TABLE_SIZE
    localparam int REM_W  = $clog2(5 * TABLE_SIZE);

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_FIND   = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_SETUP,
        ST_PROBE
    } t_state;

    // One Horner step of the key modulo the table size: (rem * 5 + digit) mod TABLE_SIZE
    function automatic logic [SLOT_W-1:0] rem_step(input logic [SLOT_W-1:0]  rem,
                                                   input logic [DIGIT_W-1:0] digit);
        logic [REM_W-1:0] v;
        v = (REM_W'(rem) << 2) + REM_W'(rem) + REM_W'(digit);
        if (v >= REM_W'(4 * TABLE_SIZE)) begin
            v = v - REM_W'(4 * TABLE_SIZE);
        end else if (v >= REM_W'(3 * TABLE_SIZE)) begin
            v = v - REM_W'(3 * TABLE_SIZE);
        end else if (v >= REM_W'(2 * TABLE_SIZE)) begin
            v = v - REM_W'(2 * TABLE_SIZE);
        end else if (v >= REM_W'(TABLE_SIZE)) begin
            v = v - REM_W'(TABLE_SIZE);
        end
        return v[SLOT_W-1:0];
    endfunction

    // Sum of two slot numbers modulo the table size (both below TABLE_SIZE)
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (SLOT_W + 1)'(TABLE_SIZE)) begin
            s = s - (SLOT_W + 1)'(TABLE_SIZE);
        end
        return s[SLOT_W-1:0];
    endfunction

endpackage

[rtl/dhsd_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module dhsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/double_hash_string_dictionary.sv]
// Top level of the double-hash string dictionary: request sequencer around the key table.
//
// Usage:
//   A request (insert or find of a string of up to 11 nucleotide symbols) is taken at a
//   rising edge where start is high and busy is low. Exactly one result follows: o_valid
//   is high for one cycle with o_present (key was already stored) and o_status (probe
//   limit reached, nothing written). The receiver cannot stall; the result is taken in
//   that cycle. busy stays high until the result strobe cycle.
//   Sequence: the key is built serially over the clamped length, one key digit per cycle
//   (key and home slot built together), then the home slot is read and the table is
//   probed, one key-table read per cycle. An empty string answers in the cycle after
//   its request. A new request can be taken in the cycle of the result strobe.
//   One request is handled at a time, paced by the serial key build and the single
//   read port of the key table.
//   Reset: i_rst_n low clears control state; afterward a clearing pass writes zero to
//   all 4093 table entries, one per cycle, with busy held high.
`timescale 1ns / 1ps
module double_hash_string_dictionary
    import dhsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_req_type,
    input  logic [SYMS_W-1:0] i_symbols,
    input  logic [LEN_W-1:0]  i_length,
    output logic              o_valid,
    output logic              o_present,
    output logic              o_status
);

    // Registers
    t_state              r_state;
    logic [SLOT_W-1:0]   r_clr;
    logic                r_valid;
    logic                r_present;
    logic                r_status;
    logic                r_find;
    logic [SYMS_W-1:0]   r_symbols;
    logic [IDX_W-1:0]    r_idx;
    logic [KEY_W-1:0]    r_key;
    logic [SLOT_W-1:0]   r_rem;
    logic [SLOT_W-1:0]   r_slot;
    logic [SLOT_W-1:0]   r_step;
    logic [SLOT_W-1:0]   r_cnt;

    // Next values
    t_state              n_state;
    logic [SLOT_W-1:0]   n_clr;
    logic                n_valid;
    logic                n_present;
    logic                n_status;
    logic                n_find;
    logic [SYMS_W-1:0]   n_symbols;
    logic [IDX_W-1:0]    n_idx;
    logic [KEY_W-1:0]    n_key;
    logic [SLOT_W-1:0]   n_rem;
    logic [SLOT_W-1:0]   n_slot;
    logic [SLOT_W-1:0]   n_step;
    logic [SLOT_W-1:0]   n_cnt;

    // Datapath wires
    logic                accept;
    logic [LEN_W-1:0]    len_cl;
    logic [SYMS_W-1:0]   sym_sh;
    logic [DIGIT_W-1:0]  digit;
    logic [SLOT_W:0]     step_raw;
    logic [SLOT_W-1:0]   step_mod;
    logic [SLOT_W-1:0]   next_slot;
    logic [KEY_W-1:0]    rd_key;
    logic                hit;
    logic                empty;
    logic                last;

    // RAM controls
    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [KEY_W-1:0]    ram_wdata;
    logic                ram_re;
    logic [SLOT_W-1:0]   ram_raddr;

    // Key table
    dhsd_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SIZE)
    ) u_key_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_key)
    );

    // Request handshake and length clamp
    assign busy   = (r_state != ST_IDLE);
    assign accept = start && (r_state == ST_IDLE);
    assign len_cl = (int'(i_length) > MAX_SYMBOLS) ? LEN_W'(MAX_SYMBOLS) : i_length;

    // Current digit: symbols past the field read as A (digit 1)
    assign sym_sh = r_symbols >> {r_idx, 1'b0};
    assign digit  = DIGIT_W'(sym_sh[1:0]) + DIGIT_W'(1);

    // Probe step from the low key bits, reduced once
    always_comb begin
        step_raw = {1'b0, r_key[SLOT_W-1:0] & SLOT_W'(TABLE_SIZE - 1)} + (SLOT_W + 1)'(1);
        if (step_raw >= (SLOT_W + 1)'(TABLE_SIZE)) begin
            step_mod = SLOT_W'(step_raw - (SLOT_W + 1)'(TABLE_SIZE));
        end else begin
            step_mod = step_raw[SLOT_W-1:0];
        end
    end

    // Probe outcome
    assign next_slot = slot_add(r_slot, r_step);
    assign hit       = (rd_key == r_key);
    assign empty     = (rd_key == '0);
    assign last      = (r_cnt == SLOT_W'(TABLE_SIZE - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == SLOT_W'(TABLE_SIZE - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && (len_cl != '0)) begin
                    n_state = ST_HASH;
                end
            end
            ST_HASH: begin
                if (r_idx == '0) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = ST_PROBE;
            end
            ST_PROBE: begin
                if (hit || empty || last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Datapath, result and RAM controls
    always_comb begin
        n_clr     = r_clr;
        n_valid   = 1'b0;
        n_present = r_present;
        n_status  = r_status;
        n_find    = r_find;
        n_symbols = r_symbols;
        n_idx     = r_idx;
        n_key     = r_key;
        n_rem     = r_rem;
        n_slot    = r_slot;
        n_step    = r_step;
        n_cnt     = r_cnt;
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = r_key;
        ram_re    = 1'b0;
        ram_raddr = r_slot;
        case (r_state)
            // Sweep zeros through the table after reset
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + SLOT_W'(1);
            end
            // Capture request; an empty string has key 0 and reads as present
            ST_IDLE: begin
                if (accept) begin
                    n_find    = (i_req_type == REQ_FIND);
                    n_symbols = i_symbols;
                    n_idx     = IDX_W'(len_cl - LEN_W'(1));
                    n_key     = '0;
                    n_rem     = '0;
                    if (len_cl == '0) begin
                        n_valid   = 1'b1;
                        n_present = 1'b1;
                        n_status  = 1'b0;
                    end
                end
            end
            // Horner step, highest symbol first; key and key mod size together
            ST_HASH: begin
                n_key = (r_key << 2) + r_key + KEY_W'(digit);
                n_rem = rem_step(r_rem, digit);
                n_idx = r_idx - IDX_W'(1);
            end
            // Home slot read, step latched
            ST_SETUP: begin
                n_slot    = r_rem;
                n_step    = step_mod;
                n_cnt     = '0;
                ram_re    = 1'b1;
                ram_raddr = r_rem;
            end
            // Compare stored key; continue with the next slot read at once
            ST_PROBE: begin
                if (hit) begin
                    n_valid   = 1'b1;
                    n_present = 1'b1;
                    n_status  = 1'b0;
                end else if (empty) begin
                    n_valid   = 1'b1;
                    n_present = 1'b0;
                    n_status  = 1'b0;
                    ram_we    = !r_find;
                end else if (last) begin
                    n_valid   = 1'b1;
                    n_present = 1'b0;
                    n_status  = 1'b1;
                end else begin
                    n_slot    = next_slot;
                    n_cnt     = r_cnt + SLOT_W'(1);
                    ram_re    = 1'b1;
                    ram_raddr = next_slot;
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_present <= n_present;
        r_status  <= n_status;
        r_find    <= n_find;
        r_symbols <= n_symbols;
        r_idx     <= n_idx;
        r_key     <= n_key;
        r_rem     <= n_rem;
        r_slot    <= n_slot;
        r_step    <= n_step;
        r_cnt     <= n_cnt;
    end

    assign o_valid   = r_valid;
    assign o_present = r_present;
    assign o_status  = r_status;

endmodule

[tb/double_hash_string_dictionary_tb.sv]
// Testbench for the double-hash string dictionary: random requests against a key-table model.
`timescale 1ns / 1ps
module double_hash_string_dictionary_tb;
    import dhsd_pkg::*;

    localparam int RANDOM_ITEMS = 1700;
    localparam int HOT_SLOTS    = 8;

    // Expected answer to one request
    typedef struct packed {
        logic present;
        logic status;
    } t_answer;

    // A nucleotide string as it is driven on the request ports
    typedef struct packed {
        logic [SYMS_W-1:0] syms;
        logic [LEN_W-1:0]  len;
    } t_word;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_req_type;
    logic [SYMS_W-1:0] i_symbols;
    logic [LEN_W-1:0]  i_length;
    logic              o_valid;
    logic              o_present;
    logic              o_status;

    int          idle_pct;
    int unsigned sent;
    t_word       stored_words[$];
    int unsigned hot_slots[HOT_SLOTS];

    double_hash_string_dictionary DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req_type (i_req_type),
        .i_symbols  (i_symbols),
        .i_length   (i_length),
        .o_valid    (o_valid),
        .o_present  (o_present),
        .o_status   (o_status)
    );

    // Base-5 key with digits 1..4, length clamped, symbols past the field read as A
    function automatic logic [KEY_W-1:0] string_key(input logic [SYMS_W-1:0] syms,
                                                    input logic [LEN_W-1:0]  len);
        int unsigned n;
        int unsigned total;
        int unsigned weight;
        n      = (len > MAX_SYMBOLS) ? MAX_SYMBOLS : len;
        total  = 0;
        weight = 1;
        for (int i = 0; i < n; i++) begin
            if (2 * i + 1 < SYMS_W) begin
                total += weight * (syms[2*i +: 2] + 1);
            end else begin
                total += weight;
            end
            weight *= 5;
        end
        return KEY_W'(total);
    endfunction

    // Predictor: own copy of the key table plus the queue of answers still due
    class dictionary_model;
        logic [KEY_W-1:0] stored_keys [TABLE_SIZE];
        t_answer          awaited [$];
        int unsigned      inserts, finds, hits, limit_hits, stored, checked, errors;

        function new();
            foreach (stored_keys[i]) stored_keys[i] = '0;
            inserts    = 0;
            finds      = 0;
            hits       = 0;
            limit_hits = 0;
            stored     = 0;
            checked    = 0;
            errors     = 0;
        endfunction

        // Walk the probe sequence for an accepted request and queue its answer
        function void note_request(input logic is_find, input logic [KEY_W-1:0] key);
            int unsigned k;
            int unsigned slot;
            int unsigned stride;
            int unsigned n;
            t_answer     ans;
            k           = key;
            ans.present = 1'b0;
            ans.status  = 1'b0;
            if (is_find) finds++;
            else inserts++;
            if (k == 0) begin
                // empty string matches the empty marker
                ans.present = 1'b1;
            end else begin
                slot       = k % TABLE_SIZE;
                stride     = (1 + (k & (TABLE_SIZE - 1))) % TABLE_SIZE;
                ans.status = 1'b1;
                n          = 0;
                while (ans.status && n < TABLE_SIZE) begin
                    if (stored_keys[slot] == key) begin
                        ans.present = 1'b1;
                        ans.status  = 1'b0;
                    end else if (stored_keys[slot] == '0) begin
                        ans.status = 1'b0;
                        if (!is_find) begin
                            stored_keys[slot] = key;
                            stored++;
                        end
                    end else begin
                        slot = (slot + stride) % TABLE_SIZE;
                        n++;
                    end
                end
            end
            if (ans.present) hits++;
            if (ans.status) limit_hits++;
            awaited.push_back(ans);
        endfunction

        // Compare one result strobe with the oldest answer due
        function void check_result(input logic present, input logic status);
            t_answer want;
            if (awaited.size() == 0) begin
                $display("%0t: result with none due, present=%0b status=%0b",
                         $time, present, status);
                errors++;
            end else begin
                want = awaited.pop_front();
                checked++;
                if (present !== want.present) begin
                    $display("%0t: present mismatch, expected %0b actual %0b",
                             $time, want.present, present);
                    errors++;
                end
                if (status !== want.status) begin
                    $display("%0t: status mismatch, expected %0b actual %0b",
                             $time, want.status, status);
                    errors++;
                end
            end
        endfunction
    endclass

    dictionary_model dict;

    // Mostly legal lengths, some empty and some overlong
    function automatic logic [LEN_W-1:0] random_length();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r < 3) return LEN_W'($urandom_range(MAX_SYMBOLS + 1, (1 << LEN_W) - 1));
        return LEN_W'($urandom_range(1, MAX_SYMBOLS));
    endfunction

    // Search for a string whose home slot is given, or whose stride wraps to zero
    function automatic void find_word(input bit zero_stride, input int unsigned home,
                                      output logic [SYMS_W-1:0] syms,
                                      output logic [LEN_W-1:0]  len);
        int unsigned k;
        int unsigned tries;
        tries = 0;
        do begin
            syms = SYMS_W'($urandom);
            len  = LEN_W'($urandom_range(7, MAX_SYMBOLS));
            k    = string_key(syms, len);
            tries++;
        end while (tries < 200000 &&
                   (zero_stride ? ((k & (TABLE_SIZE - 1)) != TABLE_SIZE - 1)
                                : ((k % TABLE_SIZE) != home)));
    endfunction

    // Clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Result monitor: strobe is taken at the edge that ends its cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            dict.check_result(o_present, o_status);
        end
    end

    // Present one request with random idle cycles ahead of it; return once accepted
    task automatic send_request(input logic req, input logic [SYMS_W-1:0] syms,
                                input logic [LEN_W-1:0] len);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            start      <= 1'b0;
            i_req_type <= 1'($urandom);
            i_symbols  <= SYMS_W'($urandom);
            i_length   <= LEN_W'($urandom);
            @(negedge i_clk);
        end
        start      <= 1'b1;
        i_req_type <= req;
        i_symbols  <= syms;
        i_length   <= len;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        dict.note_request(req == REQ_FIND, string_key(syms, len));
        sent++;
    endtask

    task automatic insert_word(input logic [SYMS_W-1:0] syms, input logic [LEN_W-1:0] len);
        t_word w;
        w.syms = syms;
        w.len  = len;
        stored_words.push_back(w);
        send_request(REQ_INSERT, syms, len);
    endtask

    // Occupy the home slot of a zero-stride key, then insert and look it up
    task automatic probe_limit_case();
        logic [SYMS_W-1:0] s0, sc;
        logic [LEN_W-1:0]  l0, lc;
        find_word(1'b1, 0, s0, l0);
        find_word(1'b0, string_key(s0, l0) % TABLE_SIZE, sc, lc);
        insert_word(sc, lc);
        send_request(REQ_INSERT, s0, l0);
        send_request(REQ_FIND, s0, l0);
    endtask

    // Timeout
    initial begin
        #60_000_000;
        $display("double_hash_string_dictionary verification failed");
        $finish;
    end

    // Stimulus
    initial begin
        logic [SYMS_W-1:0] s;
        logic [LEN_W-1:0]  l;
        t_word             w;
        int unsigned       pick, target, lens, guard, home;
        logic [SYMS_W-1:0] mask;
        int                phase_idle[3];

        dict       = new();
        sent       = 0;
        idle_pct   = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req_type = 1'b0;
        i_symbols  = '0;
        i_length   = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty string, single symbol, extremes, clamping, tail bits
        send_request(REQ_FIND, '0, '0);
        send_request(REQ_INSERT, '1, '0);
        send_request(REQ_INSERT, '0, LEN_W'(1));
        send_request(REQ_FIND, SYMS_W'(22'h3FFFFC), LEN_W'(1));
        send_request(REQ_INSERT, '0, LEN_W'(1));
        send_request(REQ_FIND, '1, LEN_W'(MAX_SYMBOLS));
        send_request(REQ_INSERT, '1, LEN_W'(MAX_SYMBOLS));
        send_request(REQ_INSERT, '1, '1);
        send_request(REQ_FIND, '1, LEN_W'(12));
        send_request(REQ_FIND, '0, LEN_W'(MAX_SYMBOLS));
        send_request(REQ_INSERT, '0, LEN_W'(MAX_SYMBOLS));
        send_request(REQ_FIND, '0, LEN_W'(13));
        s = SYMS_W'($urandom);
        send_request(REQ_INSERT, s, LEN_W'(3));
        send_request(REQ_FIND, {~s[SYMS_W-1:6], s[5:0]}, LEN_W'(3));

        // Directed: probe limit through a zero stride, then a zero stride with a free home
        probe_limit_case();
        find_word(1'b1, 0, s, l);
        send_request(REQ_INSERT, s, l);
        send_request(REQ_FIND, s, l);

        // Directed: short collision chain on one home slot
        home = $urandom_range(0, TABLE_SIZE - 1);
        repeat (3) begin
            find_word(1'b0, home, s, l);
            insert_word(s, l);
        end
        send_request(REQ_FIND, stored_words[$].syms, stored_words[$].len);

        // Random part over three sender pacing phases
        foreach (hot_slots[i]) hot_slots[i] = $urandom_range(0, TABLE_SIZE - 1);
        phase_idle[0] = 0;
        phase_idle[1] = 84;
        phase_idle[2] = 6;
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = phase_idle[phase];
            target   = sent + RANDOM_ITEMS / 3;
            while (sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    insert_word(SYMS_W'($urandom), random_length());
                end else if (pick < 45) begin
                    // cluster on a few hot home slots for long probe chains
                    find_word(1'b0, hot_slots[$urandom_range(0, HOT_SLOTS - 1)], s, l);
                    insert_word(s, l);
                end else if (pick < 75 && stored_words.size() > 0) begin
                    w    = stored_words[$urandom_range(0, stored_words.size() - 1)];
                    lens = (w.len > MAX_SYMBOLS) ? MAX_SYMBOLS : w.len;
                    if (lens < MAX_SYMBOLS && $urandom_range(0, 1)) begin
                        // bits past the string length must not matter
                        mask   = (SYMS_W'(1) << (2 * lens)) - SYMS_W'(1);
                        w.syms = (w.syms & mask) | (SYMS_W'($urandom) & ~mask);
                    end
                    send_request(pick < 65 ? REQ_FIND : REQ_INSERT, w.syms, w.len);
                end else if (pick < 90) begin
                    send_request(REQ_FIND, SYMS_W'($urandom), random_length());
                end else if (pick < 92) begin
                    probe_limit_case();
                end else if (pick < 96) begin
                    find_word(1'b1, 0, s, l);
                    send_request(1'($urandom), s, l);
                end else begin
                    send_request(1'($urandom), SYMS_W'($urandom), LEN_W'($urandom));
                end
            end
        end

        @(negedge i_clk);
        start <= 1'b0;

        // Drain: one request may still be probing the whole table
        guard = 0;
        while (dict.awaited.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (32) @(posedge i_clk);

        if (dict.awaited.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, dict.awaited.size());
            dict.errors++;
        end
        $display("Covered %0d requests (%0d inserts, %0d finds) at three sender pacings",
                 sent, dict.inserts, dict.finds);
        $display("%0d results compared: %0d present, %0d at probe limit, %0d keys stored",
                 dict.checked, dict.hits, dict.limit_hits, dict.stored);
        if (dict.errors == 0) begin
            $display("double_hash_string_dictionary verification clean");
        end else begin
            $display("double_hash_string_dictionary verification failed");
        end
        $finish;
    end

endmodule
